>>> design/lzssr_pkg.sv
// ============================================================================
// lzssr_pkg
// Shared constants and types of the LZSS ring decompressor: history ring
// geometry, match length offset and the result item carried to the output.
// ============================================================================
`default_nettype none

package lzssr_pkg;

    // History ring geometry
    localparam int HIST_DEPTH = 4096;
    localparam int RING_AW    = $clog2(HIST_DEPTH);

    // Shortest back-reference; the 4-bit length code adds to it
    localparam int LEN_BIAS = 3;

    // First write position of a stream and the byte an unwritten entry holds
    localparam logic [RING_AW-1:0] RING_START = RING_AW'(32'hFEE % HIST_DEPTH);
    localparam logic [7:0]         RING_FILL  = 8'h20;

    // One decompressed byte with its markers
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/lzssr_ring_ram.sv
// ============================================================================
// lzssr_ring_ram
// History ring storage: one write port and one read port, read data
// registered. A read in the same cycle as a write to the same entry
// returns the old contents.
// ============================================================================
`default_nettype none

module lzssr_ring_ram (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [lzssr_pkg::RING_AW-1:0] waddr,
    input  wire logic [7:0]                  wdata,
    input  wire logic                        re,
    input  wire logic [lzssr_pkg::RING_AW-1:0] raddr,
    output logic      [7:0]                  rdata
);
    import lzssr_pkg::*;

    logic [7:0] mem [HIST_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/lzssr_out_fifo.sv
// ============================================================================
// lzssr_out_fifo
// Two-entry result buffer between the copy pipeline and the output stream.
// Decouples the producer from receiver stalls; reports its fill level so
// the producer issues only what the buffer can take.
// ============================================================================
`default_nettype none

module lzssr_out_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lzssr_pkg::out_item_t  push_item,
    output logic                       valid,
    input  wire logic                  ready,
    output lzssr_pkg::out_item_t       head_item,
    output logic [1:0]                 count
);
    import lzssr_pkg::*;

    out_item_t  entry_reg [2];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop       = valid && ready;
    assign valid     = (count_reg != 2'd0);
    assign head_item = entry_reg[head_reg];
    assign count     = count_reg;

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_item;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= ~tail_reg;
            end
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/lzss_ring_decompressor.sv
// ============================================================================
// lzss_ring_decompressor
// LZSS decoder with a 4 KiB history ring: flag bytes, literals and two-byte
// back-references in, decompressed bytes out.
// ============================================================================
// Usage:
//   Write output_length on cfg_we/cfg_wdata while the block is idle. Feed
//   compressed bytes on the s_ channel (s_tdata byte, s_tlast on the final
//   byte). Decompressed bytes leave on the m_ channel: m_tlast marks the last
//   byte caused by one input transfer, m_tuser[0] the byte that reaches
//   output_length.
//   One input byte is taken at a time. Each byte returns through the finish
//   state to idle; a literal first passes the literal state, a back-reference
//   the copy state. The copy runs one byte per cycle through the ring memory
//   while the output buffer has room (one registered read and one write a
//   cycle, last written byte forwarded). A two-entry output buffer absorbs
//   stalls; the copy pauses once the buffer is full and no bytes are lost.
//   Unwritten ring entries read as spaces by a fill count measured from the
//   start position, so reset and stream end need no clearing pass. At reset
//   and at stream end (s_tlast, or the final output byte) the decoder state
//   returns to its start values.
// ============================================================================
`default_nettype none

module lzss_ring_decompressor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // in_byte[7:0]
    input  wire logic        s_tlast,    // in_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,    // out_byte[7:0]
    output logic             m_tlast,    // run_last
    output logic      [0:0]  m_tuser     // stream_done
);
    import lzssr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIT,
        ST_COPY,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [7:0]         flag_bits_reg;
    logic [3:0]         bits_left_reg;
    logic [7:0]         pending_reg;
    logic               have_low_reg;
    logic [31:0]        count_reg;
    logic [31:0]        olen_reg;
    logic [RING_AW-1:0] wp_reg;
    logic [RING_AW:0]   fill_reg;
    logic [RING_AW-1:0] rd_ptr_reg;
    logic [4:0]         remain_reg;
    logic [7:0]         lit_reg;
    logic               last_reg;
    logic               init_reg;

    // Emit stage: one byte on its way to the ring and the output buffer
    logic               s1_valid_reg;
    logic               s1_lit_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_fwd_reg;
    logic               s1_filled_reg;
    logic               s1_run_last_reg;
    logic               s1_done_reg;

    logic [7:0]         ram_rdata;
    logic [1:0]         fifo_count;
    logic               pop;
    logic [2:0]         occupancy;
    logic               can_issue;
    logic               issue_lit;
    logic               issue_rd;
    logic [31:0]        count_next;
    logic               hit_len;
    logic               fwd_hit;
    logic [RING_AW-1:0] rd_off;
    logic               rd_filled;
    logic [7:0]         emit_byte;
    logic [4:0]         copy_len;
    logic [11:0]        copy_loc;
    out_item_t          push_item;
    out_item_t          head_item;

    // Issue only what the output buffer can still take
    assign pop       = m_tvalid && m_tready;
    assign occupancy = 3'(fifo_count) + 3'(s1_valid_reg) - 3'(pop);
    assign can_issue = (occupancy < 3'd2);
    assign issue_lit = (state_reg == ST_LIT) && can_issue;
    assign issue_rd  = (state_reg == ST_COPY) && can_issue;

    assign count_next = count_reg + 32'd1;
    assign hit_len    = (count_next == olen_reg);

    // Forward the byte written this cycle; mask entries not yet written
    assign fwd_hit   = s1_valid_reg && (rd_ptr_reg == wp_reg);
    assign rd_off    = rd_ptr_reg - RING_START;
    assign rd_filled = (fill_reg > {1'b0, rd_off});

    assign emit_byte = (s1_lit_reg || s1_fwd_reg) ? s1_byte_reg :
                       (s1_filled_reg ? ram_rdata : RING_FILL);

    // Decode a back-reference from the held low byte and this byte
    assign copy_len = 5'(s_tdata[3:0]) + 5'(LEN_BIAS);
    assign copy_loc = {s_tdata[7:4], pending_reg};

    assign s_tready = (state_reg == ST_IDLE);

    assign push_item.out_byte    = emit_byte;
    assign push_item.run_last    = s1_run_last_reg;
    assign push_item.stream_done = s1_done_reg;

    assign m_tdata    = head_item.out_byte;
    assign m_tlast    = head_item.run_last;
    assign m_tuser[0] = head_item.stream_done;

    lzssr_ring_ram u_ring (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (issue_rd),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    lzssr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_item (push_item),
        .valid     (m_tvalid),
        .ready     (m_tready),
        .head_item (head_item),
        .count     (fifo_count)
    );

    // Emit stage payload
    always_ff @(posedge clk)
    begin
        if (issue_lit || issue_rd)
        begin
            s1_lit_reg    <= issue_lit;
            s1_byte_reg   <= issue_lit ? lit_reg : emit_byte;
            s1_fwd_reg    <= fwd_hit;
            s1_filled_reg <= rd_filled;
            s1_done_reg   <= hit_len;
        end
    end

    // Token sequencer, stream state and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            flag_bits_reg   <= 8'd0;
            bits_left_reg   <= 4'd0;
            pending_reg     <= 8'd0;
            have_low_reg    <= 1'b0;
            count_reg       <= 32'd0;
            olen_reg        <= 32'd0;
            wp_reg          <= RING_START;
            fill_reg        <= '0;
            rd_ptr_reg      <= '0;
            remain_reg      <= 5'd0;
            lit_reg         <= 8'd0;
            last_reg        <= 1'b0;
            init_reg        <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_run_last_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_lit || issue_rd;

            // Commit the emitted byte to the ring position and fill count
            if (s1_valid_reg)
            begin
                wp_reg <= wp_reg + RING_AW'(1);
                if (fill_reg != (RING_AW + 1)'(HIST_DEPTH))
                begin
                    fill_reg <= fill_reg + (RING_AW + 1)'(1);
                end
            end

            if (issue_lit || issue_rd)
            begin
                count_reg <= count_next;
            end

            if (cfg_we)
            begin
                olen_reg <= cfg_wdata;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        last_reg <= s_tlast;
                        init_reg <= s_tlast;
                        state_reg <= ST_FINISH;
                        if (count_reg < olen_reg)
                        begin
                            if (bits_left_reg == 4'd0)
                            begin
                                // Load a new flag byte
                                flag_bits_reg <= s_tdata;
                                bits_left_reg <= 4'd8;
                            end
                            else if (!have_low_reg)
                            begin
                                if (flag_bits_reg[0])
                                begin
                                    lit_reg       <= s_tdata;
                                    flag_bits_reg <= flag_bits_reg >> 1;
                                    bits_left_reg <= bits_left_reg - 4'd1;
                                    state_reg     <= ST_LIT;
                                end
                                else if (!s_tlast)
                                begin
                                    pending_reg  <= s_tdata;
                                    have_low_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                rd_ptr_reg    <= RING_AW'(copy_loc);
                                remain_reg    <= copy_len;
                                pending_reg   <= 8'd0;
                                have_low_reg  <= 1'b0;
                                flag_bits_reg <= flag_bits_reg >> 1;
                                bits_left_reg <= bits_left_reg - 4'd1;
                                state_reg     <= ST_COPY;
                            end
                        end
                    end
                end

                ST_LIT:
                begin
                    if (issue_lit)
                    begin
                        s1_run_last_reg <= 1'b1;
                        init_reg        <= last_reg || hit_len;
                        state_reg       <= ST_FINISH;
                    end
                end

                ST_COPY:
                begin
                    if (issue_rd)
                    begin
                        rd_ptr_reg      <= rd_ptr_reg + RING_AW'(1);
                        remain_reg      <= remain_reg - 5'd1;
                        s1_run_last_reg <= (remain_reg == 5'd1) || hit_len;
                        if ((remain_reg == 5'd1) || hit_len)
                        begin
                            init_reg  <= last_reg || hit_len;
                            state_reg <= ST_FINISH;
                        end
                    end
                end

                ST_FINISH:
                begin
                    // Wait for the last byte to land, then return to idle; restart the stream at its end
                    if (!s1_valid_reg)
                    begin
                        if (init_reg)
                        begin
                            flag_bits_reg <= 8'd0;
                            bits_left_reg <= 4'd0;
                            pending_reg   <= 8'd0;
                            have_low_reg  <= 1'b0;
                            count_reg     <= 32'd0;
                            wp_reg        <= RING_START;
                            fill_reg      <= '0;
                        end
                        init_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/lzssr_port_checker.sv
// ============================================================================
// lzssr_port_checker
// Port-level checks of the LZSS ring decompressor, bound to the top level.
// ============================================================================
`default_nettype none

module lzssr_port_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [0:0] m_tuser
);

    // Hold a stalled output transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // The byte that completes the stream ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("stream_done without run_last");

    // One input byte at a time: no input transfer right after another
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

endmodule

bind lzss_ring_decompressor lzssr_port_checker u_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
